// File: hdl/dsrg_pkg.sv
// ----------------------------------------------------------------------------
// dsrg_pkg
// Shared types, register indexes and the sine/cosine table builder for the
// delayed sine reference generator.
// ----------------------------------------------------------------------------
package dsrg_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CORDIC_STEPS   = 30;
   localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

   // arctangent of 2^-i as a fraction of a turn, 2^32 per turn
   localparam longint ATAN_TURNS [CORDIC_STEPS] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
      64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
      64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772, 64'sd166886,
      64'sd83443, 64'sd41722, 64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608,
      64'sd1304, 64'sd652, 64'sd326, 64'sd163, 64'sd81, 64'sd41, 64'sd20,
      64'sd10, 64'sd5, 64'sd3, 64'sd1
   };

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP        = 3'd0,
      CSR_START_TICK        = 3'd1,
      CSR_AMPLITUDE         = 3'd2,
      CSR_VELOCITY_GAIN     = 3'd3,
      CSR_ACCELERATION_GAIN = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [31:0] phase_step;
      logic [31:0] start_tick;
   } front_cfg_type;

   typedef struct packed {
      logic [31:0] amplitude;
      logic [31:0] velocity_gain;
      logic [31:0] acceleration_gain;
   } gain_type;

   // cos (upper half) and sin (lower half) in Q2.30 of the first-quadrant
   // angle k / 2^table_bits of a turn, evaluated at elaboration only
   function automatic logic [63:0] cordic_entry(input int unsigned k,
                                                input int unsigned table_bits);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = CORDIC_GAIN_Q30;
      y = 0;
      z = longint'(k) << (32 - table_bits);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURNS[i];
         end
      end
      return {x[31:0], y[31:0]};
   endfunction

endpackage

// File: hdl/dsrg_front.sv
// ----------------------------------------------------------------------------
// dsrg_front
// Accepts tick transactions, tests the start condition, advances the tick
// counter and phase accumulator, and queues the table index for the back end.
// ----------------------------------------------------------------------------
module dsrg_front
   import dsrg_pkg::*;
#(
   parameter int TABLE_BITS = 10,
   parameter int PHASE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_tick,
   input  front_cfg_type         cfg,
   input  logic                  queue_full,
   output logic                  push,
   output logic [TABLE_BITS:0]   push_data
);

   logic [31:0]           tick_count_ff;
   logic [31:0]           tick_count_in;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [PHASE_BITS-1:0] phase_in;
   logic [PHASE_BITS-1:0] step;
   logic                  running;

   generate
      if (PHASE_BITS > 32) begin : g_step_wide
         assign step = {cfg.phase_step, (PHASE_BITS-32)'(0)};
      end else if (PHASE_BITS == 32) begin : g_step_same
         assign step = cfg.phase_step;
      end else begin : g_step_narrow
         assign step = cfg.phase_step[31 -: PHASE_BITS];
      end
   endgenerate

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign running   = tick_count_ff >= cfg.start_tick;
   assign push_data = {running, phase_ff[PHASE_BITS-1 -: TABLE_BITS]};

   always_comb begin
      tick_count_in = tick_count_ff;
      phase_in      = phase_ff;
      if (push) begin
         if (running) begin
            if (req_tick) begin
               phase_in = phase_ff + step;
            end
         end else begin
            // phase restarts from zero at the start tick
            phase_in = '0;
            if (req_tick) begin
               tick_count_in = tick_count_ff + 32'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         phase_ff      <= '0;
      end else begin
         tick_count_ff <= tick_count_in;
         phase_ff      <= phase_in;
      end
   end

endmodule

// File: hdl/dsrg_queue.sv
// ----------------------------------------------------------------------------
// dsrg_queue
// Small first-in first-out queue that decouples the front end from the
// arithmetic back end.
// ----------------------------------------------------------------------------
module dsrg_queue
   import dsrg_pkg::*;
#(
   parameter int WIDTH = 11
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty,
   output logic             full
);

   localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;

   assign empty    = count_ff == '0;
   assign full     = count_ff == COUNT_BITS'(QUEUE_DEPTH);
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: hdl/dsrg_back.sv
// ----------------------------------------------------------------------------
// dsrg_back
// Quarter-wave table read, quadrant folding, gain multiplies and rounding
// with saturation to signed Q16.16, in a four-stage pipeline.
// ----------------------------------------------------------------------------
module dsrg_back
   import dsrg_pkg::*;
#(
   parameter int TABLE_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  logic [TABLE_BITS:0] queue_data,
   output logic                pop,
   input  gain_type            gains,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_position,
   output logic signed [31:0]  rsp_velocity,
   output logic signed [31:0]  rsp_acceleration,
   output logic                rsp_running
);

   localparam int QUARTER_BITS = TABLE_BITS - 2;
   localparam int QUARTER      = 1 << QUARTER_BITS;

   logic signed [31:0] rom_cos [QUARTER];
   logic signed [31:0] rom_sin [QUARTER];

   generate
      for (genvar g = 0; g < QUARTER; g++) begin : g_rom
         localparam logic [63:0] ENTRY = cordic_entry(g, TABLE_BITS);
         assign rom_cos[g] = ENTRY[63:32];
         assign rom_sin[g] = ENTRY[31:0];
      end
   endgenerate

   // round half away from zero to Q16.16 and saturate
   function automatic logic [31:0] round_sat(input logic [63:0] prod,
                                             input logic neg);
      logic [63:0] sum;
      logic [33:0] mag;
      logic [31:0] res;
      sum = prod + 64'h2000_0000;
      mag = sum[63:30];
      if (neg) begin
         res = (mag >= 34'h0_8000_0000) ? 32'h8000_0000 : 32'(-mag);
      end else begin
         res = (mag > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end
      return res;
   endfunction

   logic advance;

   // stage 1: table data
   logic                   s1_valid_ff;
   logic                   s1_running_ff;
   logic [1:0]             s1_quadrant_ff;
   logic signed [31:0]     s1_cos_ff;
   logic signed [31:0]     s1_sin_ff;

   // stage 2: folded magnitudes and signs
   logic                   s2_valid_ff;
   logic                   s2_running_ff;
   logic [31:0]            s2_sin_mag_ff;
   logic [31:0]            s2_cos_mag_ff;
   logic                   s2_sin_neg_ff;
   logic                   s2_cos_neg_ff;
   logic [31:0]            sin_mag_in;
   logic [31:0]            cos_mag_in;
   logic                   sin_neg_in;
   logic                   cos_neg_in;
   logic [31:0]            abs_cos;
   logic [31:0]            abs_sin;

   // stage 3: products
   logic                   s3_valid_ff;
   logic                   s3_running_ff;
   logic [63:0]            s3_pos_ff;
   logic [63:0]            s3_vel_ff;
   logic [63:0]            s3_acc_ff;
   logic                   s3_sin_neg_ff;
   logic                   s3_cos_neg_ff;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_running_ff;
   logic [31:0]            rsp_position_ff;
   logic [31:0]            rsp_velocity_ff;
   logic [31:0]            rsp_acceleration_ff;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign pop     = advance && !queue_empty;

   assign abs_cos = s1_cos_ff[31] ? 32'(-s1_cos_ff) : s1_cos_ff;
   assign abs_sin = s1_sin_ff[31] ? 32'(-s1_sin_ff) : s1_sin_ff;

   always_comb begin
      case (s1_quadrant_ff)
         2'd0: begin
            sin_mag_in = abs_sin;
            sin_neg_in = s1_sin_ff[31];
            cos_mag_in = abs_cos;
            cos_neg_in = s1_cos_ff[31];
         end
         2'd1: begin
            sin_mag_in = abs_cos;
            sin_neg_in = s1_cos_ff[31];
            cos_mag_in = abs_sin;
            cos_neg_in = !s1_sin_ff[31];
         end
         2'd2: begin
            sin_mag_in = abs_sin;
            sin_neg_in = !s1_sin_ff[31];
            cos_mag_in = abs_cos;
            cos_neg_in = !s1_cos_ff[31];
         end
         default: begin
            sin_mag_in = abs_cos;
            sin_neg_in = !s1_cos_ff[31];
            cos_mag_in = abs_sin;
            cos_neg_in = s1_sin_ff[31];
         end
      endcase
      // before the start tick every product is zero
      if (!s1_running_ff) begin
         sin_mag_in = '0;
         cos_mag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_running_ff  <= queue_data[TABLE_BITS];
         s1_quadrant_ff <= queue_data[TABLE_BITS-1 -: 2];
         s1_cos_ff      <= rom_cos[queue_data[QUARTER_BITS-1:0]];
         s1_sin_ff      <= rom_sin[queue_data[QUARTER_BITS-1:0]];

         s2_running_ff  <= s1_running_ff;
         s2_sin_mag_ff  <= sin_mag_in;
         s2_cos_mag_ff  <= cos_mag_in;
         s2_sin_neg_ff  <= sin_neg_in;
         s2_cos_neg_ff  <= cos_neg_in;

         s3_running_ff  <= s2_running_ff;
         s3_pos_ff      <= 64'(gains.amplitude) * 64'(s2_sin_mag_ff);
         s3_vel_ff      <= 64'(gains.velocity_gain) * 64'(s2_cos_mag_ff);
         s3_acc_ff      <= 64'(gains.acceleration_gain) * 64'(s2_sin_mag_ff);
         s3_sin_neg_ff  <= s2_sin_neg_ff;
         s3_cos_neg_ff  <= s2_cos_neg_ff;

         rsp_running_ff      <= s3_running_ff;
         rsp_position_ff     <= round_sat(s3_pos_ff, s3_sin_neg_ff);
         rsp_velocity_ff     <= round_sat(s3_vel_ff, s3_cos_neg_ff);
         rsp_acceleration_ff <= round_sat(s3_acc_ff, !s3_sin_neg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !queue_empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running      = rsp_running_ff;
   assign rsp_position     = rsp_position_ff;
   assign rsp_velocity     = rsp_velocity_ff;
   assign rsp_acceleration = rsp_acceleration_ff;

endmodule

// File: hdl/delayed_sine_reference_generator.sv
// ----------------------------------------------------------------------------
// delayed_sine_reference_generator
// Sinusoidal position, velocity and acceleration reference that starts at a
// configured tick, built on a phase accumulator and a sine/cosine table.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while its queue is not full and
// returns one result per transaction, in order. A result passes through the
// queue and then the s1, s2, s3 and output registers, and can be taken at the
// next clock edge when the result side is not stalled. A four-entry queue sits
// between the tick counter and phase accumulator in front and the four-stage
// table, multiply and rounding pipeline behind, and keeps requests flowing while
// results are held. The sine/cosine table holds 2^(TABLE_BITS-2) first-quadrant
// entries computed at elaboration and folded into the other quadrants; it needs
// no fill after reset. The user must write registers through the csr port only
// while no transaction is in flight; the block itself does not enforce this.
module delayed_sine_reference_generator
   import dsrg_pkg::*;
#(
   parameter int TABLE_BITS = 10,
   parameter int PHASE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_tick,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_position,
   output logic signed [31:0]        rsp_velocity,
   output logic signed [31:0]        rsp_acceleration,
   output logic                      rsp_running,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   front_cfg_type front_cfg_ff;
   gain_type      gains_ff;

   logic                queue_push;
   logic [TABLE_BITS:0] queue_push_data;
   logic                queue_pop;
   logic [TABLE_BITS:0] queue_pop_data;
   logic                queue_empty;
   logic                queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cfg_ff <= '0;
         gains_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PHASE_STEP:        front_cfg_ff.phase_step    <= csr_data;
            CSR_START_TICK:        front_cfg_ff.start_tick    <= csr_data;
            CSR_AMPLITUDE:         gains_ff.amplitude         <= csr_data;
            CSR_VELOCITY_GAIN:     gains_ff.velocity_gain     <= csr_data;
            CSR_ACCELERATION_GAIN: gains_ff.acceleration_gain <= csr_data;
            default: ;
         endcase
      end
   end

   dsrg_front #(
      .TABLE_BITS (TABLE_BITS),
      .PHASE_BITS (PHASE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_tick   (req_tick),
      .cfg        (front_cfg_ff),
      .queue_full (queue_full),
      .push       (queue_push),
      .push_data  (queue_push_data)
   );

   dsrg_queue #(
      .WIDTH (TABLE_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_data (queue_push_data),
      .pop       (queue_pop),
      .pop_data  (queue_pop_data),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   dsrg_back #(
      .TABLE_BITS (TABLE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .queue_empty      (queue_empty),
      .queue_data       (queue_pop_data),
      .pop              (queue_pop),
      .gains            (gains_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_position     (rsp_position),
      .rsp_velocity     (rsp_velocity),
      .rsp_acceleration (rsp_acceleration),
      .rsp_running      (rsp_running)
   );

endmodule

// File: bench/tb_delayed_sine_reference_generator.sv
// ----------------------------------------------------------------------------
// tb_delayed_sine_reference_generator
// Self-checking bench for the delayed sine reference generator. A local
// fixed-point model (CORDIC sine/cosine, rounding and saturation) predicts
// every result. Directed cases cover the reset state, delayed start, start
// tick moves, saturation and unused register indexes. Random phases follow,
// with random register settings, sender bursts and result stalls.
// ----------------------------------------------------------------------------
module tb_delayed_sine_reference_generator
   import dsrg_pkg::*;
();

   localparam int TABLE_BITS   = 10;
   localparam int PHASE_BITS   = 32;   // model below assumes a 32-bit phase
   localparam int ROTATIONS    = 30;
   localparam int RANDOM_ITEMS = 1450;
   localparam int DRAIN_SLACK  = 8;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam logic [CSR_INDEX_BITS-1:0] FIRST_UNUSED_INDEX =
      CSR_INDEX_BITS'(CSR_ACCELERATION_GAIN + 1);

   // arctangent of 2^-i in turns, 2^32 per turn
   localparam longint ROTATION_ANGLES [0:ROTATIONS-1] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
      64'sd42667331, 64'sd21354465, 64'sd10679838, 64'sd5340245,
      64'sd2670163, 64'sd1335087, 64'sd667544, 64'sd333772, 64'sd166886,
      64'sd83443, 64'sd41722, 64'sd20861, 64'sd10430, 64'sd5215, 64'sd2608,
      64'sd1304, 64'sd652, 64'sd326, 64'sd163, 64'sd81, 64'sd41, 64'sd20,
      64'sd10, 64'sd5, 64'sd3, 64'sd1
   };

   typedef struct packed {
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] acceleration;
      logic        running;
   } reference_sample_type;

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_tick = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_position;
   logic signed [31:0] rsp_velocity;
   logic signed [31:0] rsp_acceleration;
   logic rsp_running;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // generator model state
   bit [31:0] cfg_phase_step;
   bit [31:0] cfg_start_tick;
   bit [31:0] cfg_amplitude;
   bit [31:0] cfg_velocity_gain;
   bit [31:0] cfg_acceleration_gain;
   bit [31:0] gen_tick_count;
   bit [31:0] gen_phase;

   reference_sample_type expected_samples[$];
   stall_mode_type stall_mode = STALL_NONE;
   int stall_count = 0;
   int burst_left = 0;
   int error_count = 0;
   int items_sent = 0;
   int running_items = 0;
   int results_seen = 0;
   int settings_count = 0;

   delayed_sine_reference_generator #(
      .TABLE_BITS(TABLE_BITS),
      .PHASE_BITS(PHASE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_tick(req_tick),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_position(rsp_position),
      .rsp_velocity(rsp_velocity),
      .rsp_acceleration(rsp_acceleration),
      .rsp_running(rsp_running),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sine and cosine in Q2.30, angle in turns scaled by 2^32
   function automatic void sine_cosine(input bit [31:0] angle, output longint s,
                                       output longint c);
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      x = GAIN_Q30;
      y = 0;
      z = longint'({2'b00, angle[29:0]});
      for (int i = 0; i < ROTATIONS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ROTATION_ANGLES[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ROTATION_ANGLES[i];
         end
      end
      case (angle[31:30])
         2'd0: begin s = y;  c = x;  end
         2'd1: begin s = x;  c = -y; end
         2'd2: begin s = -y; c = -x; end
         default: begin s = -x; c = y; end
      endcase
   endfunction

   // unsigned Q16.16 gain times Q2.30 wave, rounded half away from zero, saturated
   function automatic logic [31:0] scale_q16(input bit [31:0] gain, input longint w,
                                             input bit negate);
      bit neg;
      longint unsigned mag;
      longint unsigned p;
      neg = (w < 0) != negate;
      mag = (w < 0) ? longint'(-w) : longint'(w);
      p = (64'(gain) * mag + (64'd1 << 29)) >> 30;
      if (neg) begin
         if (p >= 64'h8000_0000) return 32'h8000_0000;
         return 32'(64'd0 - p);
      end
      if (p > 64'h7FFF_FFFF) return 32'h7FFF_FFFF;
      return p[31:0];
   endfunction

   function automatic reference_sample_type advance_generator(input logic tick);
      reference_sample_type r;
      bit [31:0] angle;
      longint s;
      longint c;
      r.running = gen_tick_count >= cfg_start_tick;
      if (r.running) begin
         angle = gen_phase & ~((32'd1 << (32 - TABLE_BITS)) - 32'd1);
         sine_cosine(angle, s, c);
         r.position     = scale_q16(cfg_amplitude, s, 1'b0);
         r.velocity     = scale_q16(cfg_velocity_gain, c, 1'b0);
         r.acceleration = scale_q16(cfg_acceleration_gain, s, 1'b1);
         if (tick) gen_phase = gen_phase + cfg_phase_step;
      end else begin
         r.position     = '0;
         r.velocity     = '0;
         r.acceleration = '0;
         gen_phase      = '0;
         if (tick) gen_tick_count = gen_tick_count + 32'd1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch on result %0d: %s got %h expected %h", results_seen, what, got,
               want);
      error_count++;
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      reference_sample_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected result, position", rsp_position, '0);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_position !== want.position)
               report_mismatch("position", rsp_position, want.position);
            if (rsp_velocity !== want.velocity)
               report_mismatch("velocity", rsp_velocity, want.velocity);
            if (rsp_acceleration !== want.acceleration)
               report_mismatch("acceleration", rsp_acceleration, want.acceleration);
            if (rsp_running !== want.running)
               report_mismatch("running", 32'(rsp_running), 32'(want.running));
         end
         results_seen++;
      end
   end

   // result side stall pattern
   always @(posedge clock) begin
      stall_count <= stall_count + 1;
      case (stall_mode)
         STALL_NONE:     rsp_stall <= 1'b0;
         STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 99) < 20);
         STALL_PERIODIC: rsp_stall <= ((stall_count % 7) < 3);
         default:        rsp_stall <= ($urandom_range(0, 99) < 75);
      endcase
   end

   function automatic int pick_burst();
      if ($urandom_range(0, 3) == 0) return $urandom_range(40, 80);
      return $urandom_range(1, 12);
   endfunction

   task automatic send_tick(input logic tick);
      reference_sample_type want;
      req_valid <= 1'b1;
      req_tick  <= tick;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = advance_generator(tick);
      expected_samples.push_back(want);
      items_sent++;
      if (want.running) running_items++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = pick_burst();
      end
   endtask

   task automatic csr_put(input logic [CSR_INDEX_BITS-1:0] idx, input logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      case (idx)
         CSR_PHASE_STEP:        cfg_phase_step = value;
         CSR_START_TICK:        cfg_start_tick = value;
         CSR_AMPLITUDE:         cfg_amplitude = value;
         CSR_VELOCITY_GAIN:     cfg_velocity_gain = value;
         CSR_ACCELERATION_GAIN: cfg_acceleration_gain = value;
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let every transaction in flight come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic test_reset_state();
      // registers all zero: running at once, every output zero
      send_tick(1'b0);
      send_tick(1'b1);
      wait_idle();
   endtask

   task automatic test_delayed_start();
      csr_put(CSR_PHASE_STEP, 32'h00C0_0000);
      csr_put(CSR_START_TICK, gen_tick_count + 32'd4);
      csr_put(CSR_AMPLITUDE, 32'h0001_0000);
      csr_put(CSR_VELOCITY_GAIN, 32'h0002_0000);
      csr_put(CSR_ACCELERATION_GAIN, 32'h0003_0000);
      settings_count++;
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      wait_idle();
   endtask

   task automatic test_start_tick_moves();
      // raise the start above the count, then drop it below, then raise again
      csr_put(CSR_START_TICK, gen_tick_count + 32'd3);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
      csr_put(CSR_START_TICK, gen_tick_count - 32'd1);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
      csr_put(CSR_START_TICK, gen_tick_count + 32'd2);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
      settings_count += 3;
   endtask

   task automatic test_saturation_and_quadrants();
      // quarter-turn steps from a cleared phase, full-scale gains
      csr_put(CSR_PHASE_STEP, 32'h4000_0000);
      csr_put(CSR_START_TICK, gen_tick_count + 32'd1);
      csr_put(CSR_AMPLITUDE, 32'hFFFF_FFFF);
      csr_put(CSR_VELOCITY_GAIN, 32'hFFFF_FFFF);
      csr_put(CSR_ACCELERATION_GAIN, 32'hFFFF_FFFF);
      settings_count++;
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b0);
      send_tick(1'b1);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
   endtask

   task automatic test_unused_register();
      csr_put(FIRST_UNUSED_INDEX, 32'hFFFF_FFFF);
      csr_put(FIRST_UNUSED_INDEX + CSR_INDEX_BITS'(1), $urandom);
      csr_put(FIRST_UNUSED_INDEX + CSR_INDEX_BITS'(2), 32'h0000_0000);
      send_tick(1'b1);
      send_tick(1'b1);
      wait_idle();
   endtask

   function automatic logic [31:0] pick_phase_step();
      case ($urandom_range(0, 6))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h0040_0000 * $urandom_range(1, 16);
         3: return $urandom_range(0, 32'h003F_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_start_tick();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, gen_tick_count);
         default: return gen_tick_count + $urandom_range(0, 30);
      endcase
   endfunction

   function automatic logic [31:0] pick_gain();
      case ($urandom_range(0, 6))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(0, 32'h0000_FFFF);
         3: return $urandom_range(32'h0001_0000, 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random_settings();
      int phase_items;
      int random_items;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         csr_put(CSR_PHASE_STEP, pick_phase_step());
         csr_put(CSR_START_TICK, pick_start_tick());
         csr_put(CSR_AMPLITUDE, pick_gain());
         csr_put(CSR_VELOCITY_GAIN, pick_gain());
         csr_put(CSR_ACCELERATION_GAIN, pick_gain());
         if ($urandom_range(0, 7) == 0)
            csr_put(FIRST_UNUSED_INDEX + CSR_INDEX_BITS'($urandom_range(0, 2)), $urandom);
         settings_count++;
         phase_items = $urandom_range(30, 90);
         repeat (phase_items) send_tick($urandom_range(0, 4) != 0);
         random_items += phase_items;
         wait_idle();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = pick_burst();
      test_reset_state();
      stall_mode = STALL_PERIODIC;
      test_delayed_start();
      stall_mode = STALL_LIGHT;
      test_start_tick_moves();
      stall_mode = STALL_HEAVY;
      test_saturation_and_quadrants();
      test_unused_register();
      test_random_settings();
      $display("ran %0d transactions (%0d with the sinusoid running) over %0d settings",
               items_sent, running_items, settings_count);
      $display("checked %0d results, %0d mismatches", results_seen, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("timeout with %0d results outstanding", expected_samples.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule
